### hdl/wfcr_pkg.sv
`default_nettype none
package wfcr_pkg;

	localparam logic [7:0] IDLE_SAMPLE = 8'hFF;
	localparam logic [1:0] PAIR_ONE    = 2'b01;
	localparam logic [1:0] PAIR_ZERO   = 2'b10;
	localparam int         LEN_W       = 6;
	localparam logic [LEN_W-1:0] FRAME_RESET = 6'd26;

endpackage
`default_nettype wire

### hdl/wfcr_lane.sv
`default_nettype none
module wfcr_lane #(
	parameter int CARD_BITS = 40,
	parameter int CNT_W     = 6
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 step,
	input  wire logic                 active,
	input  wire logic [1:0]           pair,
	input  wire logic [CNT_W-1:0]     len,
	output logic                      done,
	output logic [CARD_BITS-1:0]      value
);

	logic [CARD_BITS-1:0] shift_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [CNT_W-1:0]     cnt_nx;
	logic [CARD_BITS-1:0] set_vec;
	logic                 bit_ok;
	logic                 bit_one;

	always_comb begin
		bit_ok  = active && (pair == wfcr_pkg::PAIR_ONE || pair == wfcr_pkg::PAIR_ZERO);
		bit_one = active && (pair == wfcr_pkg::PAIR_ONE);
		cnt_nx  = bit_ok ? cnt_q + CNT_W'(1) : cnt_q;
		for (int j = 0; j < CARD_BITS; j++) begin
			set_vec[j] = bit_one && (cnt_q == CNT_W'(j));
		end
		value = shift_q | set_vec;
		done  = (cnt_nx >= len);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
			cnt_q   <= '0;
		end else if (step) begin
			if (done) begin
				shift_q <= '0;
				cnt_q   <= '0;
			end else begin
				shift_q <= value;
				cnt_q   <= cnt_nx;
			end
		end
	end

`ifndef ASSERT_OFF
	a_cnt_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < CNT_W'(CARD_BITS))
		else $error("bit count beyond card width");
`endif

endmodule
`default_nettype wire

### hdl/wfcr_emit.sv
`default_nettype none
module wfcr_emit #(
	parameter int READER_COUNT = 4,
	parameter int CARD_BITS    = 40
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 load,
	input  wire logic [READER_COUNT-1:0] done_mask,
	input  wire logic [CARD_BITS-1:0] done_value [READER_COUNT],
	output logic                      can_load,
	output logic                      valid,
	input  wire logic                 ready,
	output logic [1:0]                reader_number,
	output logic [CARD_BITS-1:0]      card_value,
	output logic                      last_result
);

	logic [READER_COUNT-1:0] pend_q;
	logic [CARD_BITS-1:0]    val_q [READER_COUNT];
	logic [READER_COUNT-1:0] low_bit;
	logic [READER_COUNT-1:0] pend_rest;
	logic [1:0]              sel_idx;
	logic                    pop;

	always_comb begin
		low_bit = '0;
		sel_idx = '0;
		for (int r = READER_COUNT - 1; r >= 0; r--) begin
			if (pend_q[r]) begin
				low_bit = '0;
				low_bit[r] = 1'b1;
				sel_idx = 2'(r);
			end
		end
		pop       = (|pend_q) && (!valid || ready);
		pend_rest = pend_q & ~low_bit;
		can_load  = pop ? (pend_rest == '0) : (pend_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			valid  <= 1'b0;
		end else begin
			if (load) begin
				pend_q <= done_mask;
			end else if (pop) begin
				pend_q <= pend_rest;
			end
			if (pop) begin
				valid <= 1'b1;
			end else if (ready) begin
				valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int r = 0; r < READER_COUNT; r++) begin
				val_q[r] <= done_value[r];
			end
		end
		if (pop) begin
			reader_number <= sel_idx;
			card_value    <= val_q[sel_idx[$clog2(READER_COUNT > 1 ? READER_COUNT : 2)-1:0]];
			last_result   <= (pend_rest == '0);
		end
	end

`ifndef ASSERT_OFF
	a_pending_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q != '0) && !valid |=> valid)
		else $error("pending frame not moved to result register");
	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !load && (pend_rest == '0) |=> (pend_q == '0) && last_result)
		else $error("final transaction of a batch not marked");
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> $onehot(low_bit))
		else $error("result selection not one-hot");
`endif

endmodule
`default_nettype wire

### hdl/wiegand_four_channel_receiver.sv
// Four-reader Wiegand receiver. Each pin_sample transaction is one snapshot of
// the D1/D0 line pairs (bits 2r+1:2r for reader r) taken at a pin change; an
// all-ones snapshot stores nothing. Pair 01 stores a one and pair 10 a zero,
// first bit at card_value bit 0. When a reader's count reaches frame_length
// (0 acts as 1, above CARD_BITS acts as CARD_BITS) one result carrying
// reader_number and card_value is issued and the reader is cleared; several
// readers completing on one sample give results in ascending reader order,
// last_result marking the final one. A sample passes through an input
// register and the lane update into a pending set, then leaves through the
// result register one frame per cycle while result_ready allows; a sample
// that completes N frames (up to READER_COUNT) holds the pending set until
// all N have left, and the next sample waits only for that set to drain.
// frame_length is written through the cfg channel, which is always ready,
// and should only change while idle.
`default_nettype none
module wiegand_four_channel_receiver #(
	parameter int READER_COUNT = 4,
	parameter int CARD_BITS    = 40
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [5:0]           frame_length,
	input  wire logic                 pin_valid,
	output logic                      pin_ready,
	input  wire logic [7:0]           pin_sample,
	output logic                      result_valid,
	input  wire logic                 result_ready,
	output logic [1:0]                reader_number,
	output logic [CARD_BITS-1:0]      card_value,
	output logic                      last_result
);

	localparam int CNT_W = $clog2(CARD_BITS + 1);

	logic [5:0]              frame_length_q;
	logic [7:0]              sample_s1;
	logic                    valid_s1;
	logic [CNT_W-1:0]        len;
	logic                    can_load;
	logic                    step;
	logic                    active;
	logic [READER_COUNT-1:0] done_mask;
	logic [CARD_BITS-1:0]    done_value [READER_COUNT];

	assign cfg_ready = 1'b1;
	assign step      = valid_s1 && can_load;
	assign pin_ready = !valid_s1 || can_load;
	assign active    = (sample_s1 != wfcr_pkg::IDLE_SAMPLE);

	always_comb begin
		if (frame_length_q == '0) begin
			len = CNT_W'(1);
		end else if ({1'b0, frame_length_q} > 7'(CARD_BITS)) begin
			len = CNT_W'(CARD_BITS);
		end else begin
			len = CNT_W'(frame_length_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_length_q <= wfcr_pkg::FRAME_RESET;
			valid_s1       <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				frame_length_q <= frame_length;
			end
			if (pin_valid && pin_ready) begin
				valid_s1 <= 1'b1;
			end else if (step) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pin_valid && pin_ready) begin
			sample_s1 <= pin_sample;
		end
	end

	for (genvar r = 0; r < READER_COUNT; r++) begin : g_lane
		wfcr_lane #(
			.CARD_BITS(CARD_BITS),
			.CNT_W    (CNT_W)
		) u_lane (
			.clk   (clk),
			.arst_n(arst_n),
			.step  (step),
			.active(active),
			.pair  (sample_s1[2*r+1:2*r]),
			.len   (len),
			.done  (done_mask[r]),
			.value (done_value[r])
		);
	end

	wfcr_emit #(
		.READER_COUNT(READER_COUNT),
		.CARD_BITS   (CARD_BITS)
	) u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (step),
		.done_mask    (done_mask),
		.done_value   (done_value),
		.can_load     (can_load),
		.valid        (result_valid),
		.ready        (result_ready),
		.reader_number(reader_number),
		.card_value   (card_value),
		.last_result  (last_result)
	);

endmodule
`default_nettype wire

### sim/wiegand_four_channel_receiver_test.sv
`timescale 1ns / 100ps
module wiegand_four_channel_receiver_test;

	localparam int READERS        = 4;
	localparam int CARD_W         = 40;
	localparam int PHASE_ITEMS    = 60;
	localparam int SETTLE         = 8;
	localparam int LONG_HOLD      = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam logic [1:0] PAIR_IDLE = 2'b11;
	localparam logic [1:0] PAIR_LOW  = 2'b00;

	typedef struct packed {
		logic [1:0]        reader;
		logic [CARD_W-1:0] value;
		logic              last;
	} frame_t;

	class frame_scoreboard;
		logic [CARD_W-1:0]          shift_reg[READERS];
		int                         bit_count[READERS];
		logic [wfcr_pkg::LEN_W-1:0] length_reg;
		frame_t                     pending[$];
		int                         mismatches;

		function new();
			for (int r = 0; r < READERS; r++) begin
				shift_reg[r] = '0;
				bit_count[r] = 0;
			end
			length_reg = wfcr_pkg::FRAME_RESET;
			mismatches = 0;
		endfunction

		function void set_length(logic [wfcr_pkg::LEN_W-1:0] len);
			length_reg = len;
		endfunction

		function void note_sample(logic [7:0] s);
			int         len;
			int         first_new;
			logic [1:0] pair;
			frame_t     f;
			len = length_reg;
			if (len == 0)
				len = 1;
			if (len > CARD_W)
				len = CARD_W;
			first_new = pending.size();
			if (s != wfcr_pkg::IDLE_SAMPLE) begin
				for (int r = 0; r < READERS; r++) begin
					pair = s[2*r +: 2];
					if (pair == wfcr_pkg::PAIR_ONE || pair == wfcr_pkg::PAIR_ZERO) begin
						if (pair == wfcr_pkg::PAIR_ONE && bit_count[r] < CARD_W)
							shift_reg[r][bit_count[r]] = 1'b1;
						bit_count[r]++;
					end
				end
			end
			// completion test runs even on an ignored sample
			for (int r = 0; r < READERS; r++) begin
				if (bit_count[r] >= len) begin
					f.reader = 2'(r);
					f.value  = shift_reg[r];
					f.last   = 1'b0;
					pending.push_back(f);
					shift_reg[r] = '0;
					bit_count[r] = 0;
				end
			end
			if (pending.size() > first_new)
				pending[pending.size()-1].last = 1'b1;
		endfunction

		function void check_result(logic [1:0] rn, logic [CARD_W-1:0] cv, logic lr);
			frame_t want;
			if (pending.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected frame: reader %0d value %h last %0d", rn, cv, lr);
				mismatches++;
				return;
			end
			want = pending.pop_front();
			if (want.reader !== rn || want.value !== cv || want.last !== lr) begin
				if (mismatches < 10)
					$display("mismatch: want %0d %h %0d, got %0d %h %0d",
						want.reader, want.value, want.last, rn, cv, lr);
				mismatches++;
			end
		endfunction
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [wfcr_pkg::LEN_W-1:0] frame_length = '0;
	logic                       pin_valid = 1'b0;
	logic                       pin_ready;
	logic [7:0]                 pin_sample = '0;
	logic                       result_valid;
	logic                       result_ready = 1'b0;
	logic [1:0]                 reader_number;
	logic [CARD_W-1:0]          card_value;
	logic                       last_result;

	int                 tx_idle_pct = 0;
	int                 rx_stall_pct = 0;
	logic               hold_off = 1'b0;
	int                 stuck_cycles = 0;
	frame_scoreboard    sb = new();

	logic [7:0] at_reset_len[8] = '{8'hFF, 8'h00, 8'h55, 8'hAA, 8'h99, 8'h66, 8'hE4, 8'h1B};
	logic [7:0] at_len_one[5]   = '{8'hFF, 8'h55, 8'hAA, 8'hFE, 8'h00};
	logic [7:0] at_len_two[4]   = '{8'h56, 8'h95, 8'h3F, 8'h7F};

	wiegand_four_channel_receiver #(
		.READER_COUNT(READERS),
		.CARD_BITS(CARD_W)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.frame_length(frame_length),
		.pin_valid(pin_valid),
		.pin_ready(pin_ready),
		.pin_sample(pin_sample),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.reader_number(reader_number),
		.card_value(card_value),
		.last_result(last_result)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		result_ready <= !hold_off && ($urandom_range(99) >= rx_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready)
			sb.set_length(frame_length);
		if (arst_n && pin_valid && pin_ready)
			sb.note_sample(pin_sample);
		if (arst_n && result_valid && result_ready)
			sb.check_result(reader_number, card_value, last_result);
	end

	initial begin
		while (stuck_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((cfg_valid && cfg_ready) || (pin_valid && pin_ready) ||
				(result_valid && result_ready))
				stuck_cycles = 0;
			else
				stuck_cycles++;
		end
		$display("Regression FAIL");
		$finish;
	end

	task automatic write_length(input logic [wfcr_pkg::LEN_W-1:0] len);
		cfg_valid <= 1'b1;
		frame_length <= len;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_sample(input logic [7:0] s);
		pin_valid <= 1'b1;
		pin_sample <= s;
		@(posedge clk);
		while (!pin_ready)
			@(posedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			pin_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic drain_results();
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [7:0] random_sample(input bit lockstep);
		logic [7:0] s;
		int         pick;
		if ($urandom_range(99) < 12)
			return wfcr_pkg::IDLE_SAMPLE;
		for (int r = 0; r < READERS; r++) begin
			if (lockstep) begin
				s[2*r +: 2] = $urandom_range(1) ? wfcr_pkg::PAIR_ONE : wfcr_pkg::PAIR_ZERO;
			end else begin
				pick = $urandom_range(99);
				if (pick < 40)
					s[2*r +: 2] = PAIR_IDLE;
				else if (pick < 68)
					s[2*r +: 2] = wfcr_pkg::PAIR_ONE;
				else if (pick < 96)
					s[2*r +: 2] = wfcr_pkg::PAIR_ZERO;
				else
					s[2*r +: 2] = PAIR_LOW;
			end
		end
		return s;
	endfunction

	// lockstep phases first flush every reader so that frames complete together
	task automatic run_phase(input logic [wfcr_pkg::LEN_W-1:0] len, input int idle,
		input int stall, input bit lockstep, input bit long_hold);
		drain_results();
		if (lockstep) begin
			write_length(6'd1);
			send_sample(wfcr_pkg::IDLE_SAMPLE);
			pin_valid <= 1'b0;
			drain_results();
		end
		write_length(len);
		tx_idle_pct = idle;
		rx_stall_pct = stall;
		if (long_hold) begin
			hold_off <= 1'b1;
			fork
				begin
					repeat (LONG_HOLD) @(posedge clk);
					hold_off <= 1'b0;
				end
			join_none
		end
		repeat (PHASE_ITEMS)
			send_sample(random_sample(lockstep));
		pin_valid <= 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (at_reset_len[i])
			send_sample(at_reset_len[i]);
		pin_valid <= 1'b0;
		drain_results();
		// zero acts as one; partial frames flush on the idle sample
		write_length(6'd0);
		foreach (at_len_one[i])
			send_sample(at_len_one[i]);
		pin_valid <= 1'b0;
		drain_results();
		write_length(6'd2);
		foreach (at_len_two[i])
			send_sample(at_len_two[i]);
		pin_valid <= 1'b0;

		run_phase(6'd63, 0, 0, 1'b1, 1'b0);
		run_phase(6'd26, 77, 0, 1'b0, 1'b0);
		run_phase(6'd5, 0, 77, 1'b0, 1'b0);
		run_phase(6'd1, 16, 16, 1'b0, 1'b0);
		run_phase(6'd12, 0, 0, 1'b1, 1'b1);
		run_phase(6'd33, 77, 77, 1'b0, 1'b0);
		run_phase(6'd3, 16, 16, 1'b1, 1'b0);
		run_phase(6'd40, 0, 0, 1'b0, 1'b0);
		drain_results();

		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

### files.f
hdl/wfcr_pkg.sv
hdl/wfcr_lane.sv
hdl/wfcr_emit.sv
hdl/wiegand_four_channel_receiver.sv
sim/wiegand_four_channel_receiver_test.sv
